[rtl/dpm_pkg.sv]
// Shared types and constants of the Magnus dew point block.
`default_nettype none

package dpm_pkg;

  localparam int TempWidth     = 15;
  localparam int HumWidth      = 14;
  localparam int LogFracBits   = 16;

  localparam logic [20:0] A_Q16      = 21'd1147162;
  localparam logic [14:0] B_CENTI    = 15'd24120;
  localparam logic [29:0] LN2_Q30    = 30'd744261118;
  localparam logic [17:0] RECIP_INT  = 18'd214748;
  localparam logic [11:0] RECIP_FRAC = 12'd3648;
  localparam logic [26:0] FRAC_RECIP = 27'd109951163;

  localparam logic signed [14:0] DP_MIN = -15'sd16000;
  localparam logic signed [14:0] DP_MAX = 15'sd12500;

  typedef struct packed {
    logic signed [TempWidth-1:0] temp;
    logic [HumWidth-1:0]         hum;
    logic                        invalid;
  } item_t;

endpackage

`default_nettype wire

[rtl/dpm_if.sv]
// Input and output channel interfaces of the dew point block.
`default_nettype none

interface dpm_in_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] temperature_centi;
  logic [13:0]        humidity_centi;

  modport source(output valid, temperature_centi, humidity_centi, input ready);
  modport sink(input valid, temperature_centi, humidity_centi, output ready);
endinterface

interface dpm_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] dew_point_centi;
  logic               humidity_invalid;
  logic               saturated;

  modport source(output valid, dew_point_centi, humidity_invalid, saturated, input ready);
  modport sink(input valid, dew_point_centi, humidity_invalid, saturated, output ready);
endinterface

`default_nettype wire

[rtl/dpm_front.sv]
// Front stage: registers a reading and flags a zero humidity.
`default_nettype none

module dpm_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  dpm_in_if.sink        in_i,
  output dpm_pkg::item_t item_o,
  output logic          item_valid_o,
  input  logic          item_ready_i
);
  import dpm_pkg::*;

  logic  valid_q;
  item_t item_q;

  assign in_i.ready   = !valid_q || item_ready_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.temp    <= in_i.temperature_centi;
      item_q.hum     <= in_i.humidity_centi;
      item_q.invalid <= (in_i.humidity_centi == '0);
    end
  end

endmodule

`default_nettype wire

[rtl/dpm_fifo.sv]
// Two-entry queue between the front stage and the arithmetic pipeline.
`default_nettype none

module dpm_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  dpm_pkg::item_t wr_item_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output dpm_pkg::item_t rd_item_o
);
  import dpm_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_item_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign cnt_d      = cnt_q + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

`default_nettype wire

[rtl/dpm_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
`default_nettype none

module dpm_div #(
  parameter int NW = 37,
  parameter int DW = 16,
  parameter int QW = 22,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);
  localparam int RW = NW + DW;

  logic [RW-1:0] rem_q  [QW];
  logic [DW-1:0] den_q  [QW];
  logic [QW-1:0] quo_q  [QW];
  logic [SW-1:0] side_q [QW];
  logic          vld_q  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int SH = QW - 1 - k;
    logic [RW-1:0] rem_in, trial;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [SW-1:0] side_in;
    logic          vld_in;

    if (k == 0) begin : g_first
      assign rem_in  = RW'(num_i);
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    assign trial = RW'(den_in) << SH;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
        if (rem_in >= trial) begin
          rem_q[k] <= rem_in - trial;
          quo_q[k] <= quo_in | (QW'(1) << SH);
        end else begin
          rem_q[k] <= rem_in;
          quo_q[k] <= quo_in;
        end
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

`default_nettype wire

[rtl/dpm_back.sv]
// Arithmetic pipeline: Magnus term, fixed-point logarithm, final division.
`default_nettype none

module dpm_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dpm_pkg::item_t in_item_i,
  dpm_out_if.source      out_o
);
  import dpm_pkg::*;

  typedef struct packed {
    logic        inv;
    logic        tneg;
    logic [31:0] qhi;
    logic [12:0] lf;
    logic [3:0]  z;
  } side_x_t;

  typedef struct packed {
    logic inv;
    logic bad;
    logic ovf;
    logic gneg;
  } side_p_t;

  logic en;
  logic out_vld_q;

  assign en         = !out_vld_q || out_o.ready;
  assign in_ready_o = en;

  // Stage A: normalize humidity, start both products.
  logic [3:0]         a_msb;
  logic [3:0]         a_zc;
  logic [13:0]        a_hn;
  logic [14:0]        a_tmag;
  logic signed [16:0] a_dsum;

  always_comb begin
    a_msb = 4'd0;
    for (int i = 0; i < HumWidth; i++) begin
      if (in_item_i.hum[i]) begin
        a_msb = 4'(i);
      end
    end
    a_zc   = 4'd13 - a_msb;
    a_hn   = in_item_i.hum << a_zc;
    a_tmag = in_item_i.temp[14] ? 15'(-in_item_i.temp) : 15'(in_item_i.temp);
    a_dsum = $signed({2'b00, B_CENTI}) + {{2{in_item_i.temp[14]}}, in_item_i.temp};
  end

  logic        a_vld_q, a_inv_q, a_tneg_q;
  logic [35:0] a_pm_q;
  logic [15:0] a_d_q;
  logic [31:0] a_qhi_q;
  logic [25:0] a_lo_q;
  logic [3:0]  a_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_inv_q  <= in_item_i.invalid;
      a_tneg_q <= in_item_i.temp[14];
      a_pm_q   <= 36'(A_Q16) * 36'(a_tmag);
      a_d_q    <= a_dsum[15:0];
      a_qhi_q  <= 32'(a_hn) * 32'(RECIP_INT);
      a_lo_q   <= 26'(a_hn) * 26'(RECIP_FRAC);
      a_z_q    <= a_zc;
    end
  end

  // Stage B: add half the divisor for rounding.
  // The fractional part of the humidity ratio is divided by 10000 through a reciprocal.
  logic [52:0] b_lf_prod;

  assign b_lf_prod = 53'(a_lo_q) * 53'(FRAC_RECIP);

  logic        b_vld_q;
  logic [36:0] b_nx_q;
  logic [15:0] b_d_q;
  side_x_t     b_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (en) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_nx_q        <= 37'(a_pm_q) + 37'(a_d_q >> 1);
      b_d_q         <= a_d_q;
      b_side_q.inv  <= a_inv_q;
      b_side_q.tneg <= a_tneg_q;
      b_side_q.qhi  <= a_qhi_q;
      b_side_q.lf   <= b_lf_prod[52:40];
      b_side_q.z    <= a_z_q;
    end
  end

  // Magnus term a*T/(b+T).
  logic        dx_vld;
  logic [21:0] dx_quo;
  side_x_t     dx_side;

  dpm_div #(.NW(37), .DW(16), .QW(22), .SW($bits(side_x_t))) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (b_vld_q),
    .num_i   (b_nx_q),
    .den_i   (b_d_q),
    .side_i  (b_side_q),
    .valid_o (dx_vld),
    .quo_o   (dx_quo),
    .side_o  (dx_side)
  );

  // Stage C: mantissa and exponent of the ratio.
  logic [31:0]        c_q31;
  logic               c_big;
  logic signed [22:0] c_x;

  assign c_q31 = dx_side.qhi + 32'(dx_side.lf);
  assign c_big = c_q31[31];
  assign c_x   = dx_side.tneg ? -$signed({1'b0, dx_quo}) : $signed({1'b0, dx_quo});

  logic               c_vld_q, c_inv_q;
  logic [30:0]        c_m_q;
  logic [3:0]         c_eneg_q;
  logic signed [22:0] c_x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (en) begin
      c_vld_q <= dx_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_inv_q  <= dx_side.inv;
      c_m_q    <= c_big ? c_q31[31:1] : c_q31[30:0];
      c_eneg_q <= dx_side.z + {3'b000, !c_big};
      c_x_q    <= c_x;
    end
  end

  // Log2 fraction by repeated squaring, one bit per stage.
  logic [30:0]        sq_m_q   [LogFracBits];
  logic [15:0]        sq_f_q   [LogFracBits];
  logic               sq_vld_q [LogFracBits];
  logic               sq_inv_q [LogFracBits];
  logic [3:0]         sq_e_q   [LogFracBits];
  logic signed [22:0] sq_x_q   [LogFracBits];

  for (genvar j = 0; j < LogFracBits; j++) begin : g_sq
    logic [30:0]        m_in;
    logic [15:0]        f_in;
    logic               vld_in, inv_in;
    logic [3:0]         e_in;
    logic signed [22:0] x_in;
    logic [61:0]        prod;
    logic [31:0]        s;

    if (j == 0) begin : g_first
      assign m_in   = c_m_q;
      assign f_in   = '0;
      assign vld_in = c_vld_q;
      assign inv_in = c_inv_q;
      assign e_in   = c_eneg_q;
      assign x_in   = c_x_q;
    end else begin : g_next
      assign m_in   = sq_m_q[j-1];
      assign f_in   = sq_f_q[j-1];
      assign vld_in = sq_vld_q[j-1];
      assign inv_in = sq_inv_q[j-1];
      assign e_in   = sq_e_q[j-1];
      assign x_in   = sq_x_q[j-1];
    end

    assign prod = 62'(m_in) * 62'(m_in);
    assign s    = prod[61:30];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[j] <= 1'b0;
      end else if (en) begin
        sq_vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_inv_q[j] <= inv_in;
        sq_e_q[j]   <= e_in;
        sq_x_q[j]   <= x_in;
        sq_m_q[j]   <= s[31] ? s[31:1] : s[30:0];
        sq_f_q[j]   <= {f_in[14:0], s[31]};
      end
    end
  end

  localparam int SqLast = LogFracBits - 1;

  // Stage D: log2 times ln 2.
  logic signed [21:0] d_log2;

  assign d_log2 = $signed({6'b000000, sq_f_q[SqLast]})
                - $signed({2'b00, sq_e_q[SqLast], 16'h0000});

  logic               d_vld_q, d_inv_q;
  logic signed [52:0] d_prod_q;
  logic signed [22:0] d_x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else if (en) begin
      d_vld_q <= sq_vld_q[SqLast];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_inv_q  <= sq_inv_q[SqLast];
      d_x_q    <= sq_x_q[SqLast];
      d_prod_q <= 53'(d_log2) * $signed({23'h0, LN2_Q30});
    end
  end

  // Stage E: round the logarithm to Q16.
  logic [52:0] e_mag;
  logic [52:0] e_sum;
  logic [22:0] e_lq;

  assign e_mag = d_prod_q[52] ? 53'(-d_prod_q) : 53'(d_prod_q);
  assign e_sum = e_mag + (53'(1) << 29);
  assign e_lq  = e_sum[52:30];

  logic               e_vld_q, e_inv_q;
  logic signed [23:0] e_l_q;
  logic signed [22:0] e_x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else if (en) begin
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_inv_q <= d_inv_q;
      e_x_q   <= d_x_q;
      e_l_q   <= d_prod_q[52] ? -$signed({1'b0, e_lq}) : $signed({1'b0, e_lq});
    end
  end

  // Stage F: g and the divisor a - g.
  logic               f_vld_q, f_inv_q;
  logic signed [24:0] f_g_q;
  logic signed [25:0] f_den_q;
  logic signed [24:0] f_g;

  assign f_g = 25'(e_l_q) + 25'(e_x_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (en) begin
      f_vld_q <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_inv_q <= e_inv_q;
      f_g_q   <= f_g;
      f_den_q <= $signed({5'b00000, A_Q16}) - 26'(f_g);
    end
  end

  // Stage G: b times |g|.
  logic [23:0] g_gmag;

  assign g_gmag = f_g_q[24] ? 24'(-f_g_q) : 24'(f_g_q);

  logic        g_vld_q, g_inv_q, g_gneg_q, g_bad_q;
  logic [38:0] g_pm_q;
  logic [23:0] g_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q <= 1'b0;
    end else if (en) begin
      g_vld_q <= f_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_inv_q  <= f_inv_q;
      g_gneg_q <= f_g_q[24];
      g_bad_q  <= f_den_q[25] || (f_den_q == '0);
      g_pm_q   <= 39'(B_CENTI) * 39'(g_gmag);
      g_den_q  <= f_den_q[23:0];
    end
  end

  // Stage H: rounding offset.
  logic        h_vld_q, h_inv_q, h_gneg_q, h_bad_q;
  logic [39:0] h_nd_q;
  logic [23:0] h_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_vld_q <= 1'b0;
    end else if (en) begin
      h_vld_q <= g_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_inv_q  <= g_inv_q;
      h_gneg_q <= g_gneg_q;
      h_bad_q  <= g_bad_q;
      h_nd_q   <= 40'(g_pm_q) + 40'(g_den_q >> 1);
      h_den_q  <= g_den_q;
    end
  end

  // Stage I: quotients that do not fit in 15 bits saturate.
  logic    i_ovf;
  logic    i_vld_q;
  logic [39:0] i_num_q;
  logic [23:0] i_den_q;
  side_p_t i_side_q;

  assign i_ovf = h_nd_q >= (40'(h_den_q) << 15);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_vld_q <= 1'b0;
    end else if (en) begin
      i_vld_q <= h_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      i_num_q       <= (i_ovf || h_bad_q) ? '0 : h_nd_q;
      i_den_q       <= h_den_q;
      i_side_q.inv  <= h_inv_q;
      i_side_q.bad  <= h_bad_q;
      i_side_q.ovf  <= i_ovf;
      i_side_q.gneg <= h_gneg_q;
    end
  end

  logic        dp_vld;
  logic [14:0] dp_quo;
  side_p_t     dp_side;

  dpm_div #(.NW(40), .DW(24), .QW(15), .SW($bits(side_p_t))) u_div_p (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (i_vld_q),
    .num_i   (i_num_q),
    .den_i   (i_den_q),
    .side_i  (i_side_q),
    .valid_o (dp_vld),
    .quo_o   (dp_quo),
    .side_o  (dp_side)
  );

  // Output register with clipping.
  logic signed [15:0] o_val;
  logic signed [14:0] o_dp;
  logic               o_inv, o_sat;

  always_comb begin
    o_val = dp_side.gneg ? -$signed({1'b0, dp_quo}) : $signed({1'b0, dp_quo});
    o_dp  = o_val[14:0];
    o_inv = 1'b0;
    o_sat = 1'b0;
    if (dp_side.inv) begin
      o_dp  = '0;
      o_inv = 1'b1;
    end else if (dp_side.bad) begin
      o_dp  = DP_MAX;
      o_sat = 1'b1;
    end else if (dp_side.ovf) begin
      o_dp  = dp_side.gneg ? DP_MIN : DP_MAX;
      o_sat = 1'b1;
    end else if (o_val > 16'(DP_MAX)) begin
      o_dp  = DP_MAX;
      o_sat = 1'b1;
    end else if (o_val < 16'(DP_MIN)) begin
      o_dp  = DP_MIN;
      o_sat = 1'b1;
    end
  end

  logic signed [14:0] out_dp_q;
  logic               out_inv_q, out_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dp_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_dp_q  <= o_dp;
      out_inv_q <= o_inv;
      out_sat_q <= o_sat;
    end
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.dew_point_centi  = out_dp_q;
  assign out_o.humidity_invalid = out_inv_q;
  assign out_o.saturated        = out_sat_q;

endmodule

`default_nettype wire

[rtl/dew_point_magnus.sv]
// Top level of the Magnus dew point block.
//
//   channel  dir  fields
//   in_i     in   temperature_centi, humidity_centi
//   out_o    out  dew_point_centi, humidity_invalid, saturated
//
// One reading is accepted per cycle and one result leaves per cycle while the output is not stalled.
// A result is offered once its input has passed the front register, the queue, the two
// bit-per-stage dividers and the sixteen squaring stages of the logarithm.
// Reset clears all valid bits; no clearing pass is needed.
// A stalled output freezes the pipeline; a two-entry queue and the front register take readings until they fill.
`default_nettype none

module dew_point_magnus (
  input  logic       clk_i,
  input  logic       rst_ni,
  dpm_in_if.sink     in_i,
  dpm_out_if.source  out_o
);
  import dpm_pkg::*;

  item_t f_item, q_item;
  logic  f_valid, f_ready, q_valid, q_ready;

  dpm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_o       (f_item),
    .item_valid_o (f_valid),
    .item_ready_i (f_ready)
  );

  dpm_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_item_i  (f_item),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_item_o  (q_item)
  );

  dpm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (q_valid),
    .in_ready_o (q_ready),
    .in_item_i  (q_item),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

[test/dew_point_magnus_tb.sv]
// Testbench for the Magnus dew point block: random and directed readings checked by a scoreboard.
`default_nettype none

module dew_point_magnus_tb;
  import dpm_pkg::*;

  typedef struct {
    logic signed [14:0] dp_centi;
    logic               invalid;
    logic               sat;
  } dew_result_t;

  class dew_scoreboard;
    dew_result_t pending[$];
    int          errors = 0;

    function automatic longint round_div(longint n, longint d);
      longint mag;
      longint q;
      mag = (n < 0) ? -n : n;
      q = (mag + d / 2) / d;
      return (n < 0) ? -q : q;
    endfunction

    function automatic longint ln_humidity_q16(longint h);
      longint ratio;
      longint mant;
      longint frac;
      int     msb;
      ratio = (h << 44) / 10000;
      msb = 63;
      frac = 0;
      while (msb > 0 && ratio[msb] == 1'b0) msb--;
      if (msb < 30) msb = 30;
      mant = ratio >> (msb - 30);
      for (int i = 0; i < 16; i++) begin
        mant = (mant * mant) >> 30;
        frac = frac << 1;
        if (mant >= (64'sd1 << 31)) begin
          mant = mant >> 1;
          frac = frac | 1;
        end
      end
      return round_div((longint'(msb - 44) * 65536 + frac) * longint'(LN2_Q30),
                       64'sd1 << 30);
    endfunction

    function void note_reading(logic signed [14:0] temp, logic [13:0] hum);
      dew_result_t r;
      longint      t;
      longint      g;
      longint      den;
      longint      dp;
      t = temp;
      r.invalid = 1'b0;
      r.sat = 1'b0;
      if (hum == 0) begin
        r.dp_centi = '0;
        r.invalid = 1'b1;
      end else begin
        g = ln_humidity_q16(longint'(hum)) +
            round_div(longint'(A_Q16) * t, longint'(B_CENTI) + t);
        den = longint'(A_Q16) - g;
        if (den <= 0) begin
          dp = DP_MAX;
          r.sat = 1'b1;
        end else begin
          dp = round_div(longint'(B_CENTI) * g, den);
          if (dp > DP_MAX) begin
            dp = DP_MAX;
            r.sat = 1'b1;
          end else if (dp < DP_MIN) begin
            dp = DP_MIN;
            r.sat = 1'b1;
          end
        end
        r.dp_centi = dp[14:0];
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic signed [14:0] dp, logic inv, logic sat);
      dew_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result dew_point_centi=%0d", dp);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (dp !== e.dp_centi) begin
        $error("dew_point_centi expected %0d actual %0d", e.dp_centi, dp);
        errors++;
      end
      if (inv !== e.invalid) begin
        $error("humidity_invalid expected %0b actual %0b", e.invalid, inv);
        errors++;
      end
      if (sat !== e.sat) begin
        $error("saturated expected %0b actual %0b", e.sat, sat);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   hold_off = 1'b0;
  dew_scoreboard board = new();

  dpm_in_if  in_ch();
  dpm_out_if out_ch();

  dew_point_magnus uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.temperature_centi = '0;
    in_ch.humidity_centi = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      board.check_result(out_ch.dew_point_centi, out_ch.humidity_invalid, out_ch.saturated);
    end
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      board.note_reading(in_ch.temperature_centi, in_ch.humidity_centi);
    end
  end

  always @(negedge clk_i) begin
    out_ch.ready <= rst_ni && !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_reading(logic signed [14:0] temp, logic [13:0] hum);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.temperature_centi <= temp;
    in_ch.humidity_centi <= hum;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic send_random(int count);
    logic signed [14:0] t;
    logic [13:0]        h;
    for (int i = 0; i < count; i++) begin
      t = $urandom_range(99) < 85 ? 15'($signed($urandom_range(16500)) - 4000)
                                  : 15'($urandom);
      case ($urandom_range(9))
        0: h = 14'($urandom);
        1: h = 14'($urandom_range(20));
        2: h = '0;
        default: h = 14'($urandom_range(10000));
      endcase
      send_reading(t, h);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    send_reading(-15'sd4000, 14'd10000);
    send_reading(15'sd12500, 14'd10000);
    send_reading(15'sd0, 14'd0);
    send_reading(15'sd2500, 14'd0);
    send_reading(-15'sd4000, 14'd1);
    send_reading(15'sd12500, 14'd1);
    send_reading(15'sd0, 14'd5000);
    send_reading(15'sd12500, 14'd16383);
    send_reading(15'sd16383, 14'd16383);
    send_reading(-15'sd16384, 14'd16383);
    send_reading(-15'sd16384, 14'd1);
    send_reading(15'sd16383, 14'd1);
    send_reading(-15'sd1, 14'd8191);
    send_reading(15'sd2000, 14'd10001);
    send_reading(15'sd9999, 14'd9999);
    send_reading(-15'sd3000, 14'd2);
    send_random(40);
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      send_random(120);
    join
    send_idle_pct = 28;
    recv_idle_pct = 79;
    send_random(400);
    send_idle_pct = 79;
    recv_idle_pct = 28;
    send_random(400);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(260);
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
rtl/dpm_pkg.sv
rtl/dpm_if.sv
rtl/dpm_front.sv
rtl/dpm_fifo.sv
rtl/dpm_div.sv
rtl/dpm_back.sv
rtl/dew_point_magnus.sv
test/dew_point_magnus_tb.sv
